// ===== hdl/mpwm_pkg.sv =====
`default_nettype none
package mpwm_pkg;

    localparam int NODES           = 256;
    localparam int PATTERNS        = 256;
    localparam int MAX_PATTERN_LEN = 32;
    localparam int ALPHABET        = 256;
    localparam int TICKERS         = 256;
    localparam int MAX_MATCHES     = 64;

    localparam int BW   = $clog2(ALPHABET);
    localparam int NW   = $clog2(NODES);
    localparam int NCW  = $clog2(NODES + 1);
    localparam int PW   = $clog2(PATTERNS);
    localparam int PCW  = $clog2(PATTERNS + 1);
    localparam int LW   = $clog2(MAX_PATTERN_LEN + 1);
    localparam int TPW  = $clog2(MAX_PATTERN_LEN + 2);
    localparam int TW   = $clog2(TICKERS);
    localparam int HCW  = $clog2(MAX_MATCHES + 1);
    localparam int TTW  = NW + BW;
    localparam int TTD  = NODES * ALPHABET;
    localparam int HW   = MAX_PATTERN_LEN + 1;

    localparam logic [2:0] OP_PAT_BYTE = 3'd0;
    localparam logic [2:0] OP_END_PAT  = 3'd1;
    localparam logic [2:0] OP_BUILD    = 3'd2;
    localparam logic [2:0] OP_TEXT     = 3'd3;
    localparam logic [2:0] OP_END_TEXT = 3'd4;
    localparam logic [2:0] OP_CLEAR    = 3'd5;

    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_NODE_FULL = 3'd1;
    localparam logic [2:0] STAT_TOO_LONG  = 3'd2;
    localparam logic [2:0] STAT_PHASE     = 3'd3;
    localparam logic [2:0] STAT_OVERFLOW  = 3'd4;

    typedef enum logic [4:0] {
        CS_CLR,
        CS_IDLE,
        CS_DECODE,
        CS_ACK,
        CS_P_RD,
        CS_P_EV,
        CS_E_RD,
        CS_E_WR,
        CS_B_INIT,
        CS_B0_RD,
        CS_B0_EV,
        CS_BQ,
        CS_BQ_EV,
        CS_BF_EV,
        CS_BO,
        CS_BC_RD1,
        CS_BC_RD2,
        CS_BC_EV,
        CS_S_START,
        CS_S_NODE,
        CS_S_NH,
        CS_S_P,
        CS_S_PE,
        CS_S_SEEN,
        CS_S_ADV,
        CS_S_ADV2,
        CS_S_SCLR,
        CS_S_FIN
    } state_t;

    typedef struct packed {
        state_t step;
        logic   accept;
    } cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       built;
        logic       broken;
        logic       len_full;
        logic       clr_last;
        logic       chr_last;
        logic       q_empty;
        logic       s_zero;
        logic       p_zero;
        logic       check_go;
        logic       seen_wait;
        logic       out_free;
    } sts_t;

    function automatic logic [BW-1:0] fold(input logic [BW-1:0] b);
        logic [BW-1:0] r;
        r = (b >= BW'("A") && b <= BW'("Z")) ? b + (BW'("a") - BW'("A")) : b;
        return r;
    endfunction

    function automatic logic is_word(input logic [BW-1:0] b);
        logic r;
        r = (b >= BW'("a") && b <= BW'("z")) || (b >= BW'("A") && b <= BW'("Z")) ||
            (b >= BW'("0") && b <= BW'("9")) || (b == BW'("_"));
        return r;
    endfunction

    function automatic logic [TW-1:0] tick_slot(input logic [7:0] t);
        logic [TW-1:0] r;
        r = TW'(t % TICKERS);
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/mpwm_ram.sv =====
`default_nettype none
module mpwm_ram #(
    parameter int W = 8,
    parameter int D = 256
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [$clog2(D)-1:0] waddr,
    input  wire logic [W-1:0]         wdata,
    input  wire logic                 re,
    input  wire logic [$clog2(D)-1:0] raddr,
    output logic      [W-1:0]         rdata
);
    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// ===== hdl/mpwm_ctrl.sv =====
`default_nettype none
module mpwm_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    input  wire mpwm_pkg::sts_t sts,
    output mpwm_pkg::cmd_t      cmd,
    output logic                req_stall
);
    import mpwm_pkg::*;

    state_t state_reg, state_next;
    logic   clr_ack_reg, clr_ack_next;
    state_t after_walk;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= CS_CLR;
            clr_ack_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_ack_reg <= clr_ack_next;
        end
    end

    assign after_walk = (sts.op == OP_TEXT) ? CS_S_ADV : CS_S_SCLR;

    always_comb
    begin
        state_next   = state_reg;
        clr_ack_next = clr_ack_reg;
        cmd.step     = state_reg;
        cmd.accept   = 1'b0;
        req_stall    = (state_reg != CS_IDLE);
        case (state_reg)
            CS_CLR:
            begin
                if (sts.clr_last)
                begin
                    state_next   = clr_ack_reg ? CS_ACK : CS_IDLE;
                    clr_ack_next = 1'b0;
                end
            end
            CS_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = CS_DECODE;
                end
            end
            CS_DECODE:
            begin
                case (sts.op)
                    OP_PAT_BYTE:
                        state_next = (sts.built || sts.broken || sts.len_full) ? CS_ACK : CS_P_RD;
                    OP_END_PAT:
                        state_next = sts.built ? CS_ACK : CS_E_RD;
                    OP_BUILD:
                        state_next = sts.built ? CS_ACK : CS_B_INIT;
                    OP_TEXT, OP_END_TEXT:
                        state_next = sts.built ? CS_S_START : CS_ACK;
                    OP_CLEAR:
                    begin
                        state_next   = CS_CLR;
                        clr_ack_next = 1'b1;
                    end
                    default:
                        state_next = CS_ACK;
                endcase
            end
            CS_ACK, CS_S_FIN:
            begin
                if (sts.out_free)
                begin
                    state_next = CS_IDLE;
                end
            end
            CS_P_RD:   state_next = CS_P_EV;
            CS_P_EV:   state_next = CS_ACK;
            CS_E_RD:   state_next = CS_E_WR;
            CS_E_WR:   state_next = CS_ACK;
            CS_B_INIT: state_next = CS_B0_RD;
            CS_B0_RD:  state_next = CS_B0_EV;
            CS_B0_EV:  state_next = sts.chr_last ? CS_BQ : CS_B0_RD;
            CS_BQ:     state_next = sts.q_empty ? CS_ACK : CS_BQ_EV;
            CS_BQ_EV:  state_next = CS_BF_EV;
            CS_BF_EV:  state_next = CS_BO;
            CS_BO:     state_next = CS_BC_RD1;
            CS_BC_RD1: state_next = CS_BC_RD2;
            CS_BC_RD2: state_next = CS_BC_EV;
            CS_BC_EV:  state_next = sts.chr_last ? CS_BQ : CS_BC_RD1;
            CS_S_START: state_next = sts.check_go ? CS_S_NODE : after_walk;
            CS_S_NODE: state_next = sts.s_zero ? after_walk : CS_S_NH;
            CS_S_NH:   state_next = CS_S_P;
            CS_S_P:    state_next = sts.p_zero ? CS_S_NODE : CS_S_PE;
            CS_S_PE:   state_next = CS_S_SEEN;
            CS_S_SEEN: state_next = sts.seen_wait ? CS_S_SEEN : CS_S_P;
            CS_S_ADV:  state_next = CS_S_ADV2;
            CS_S_ADV2: state_next = CS_S_FIN;
            CS_S_SCLR: state_next = sts.chr_last ? CS_S_FIN : CS_S_SCLR;
            default:   state_next = CS_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ===== hdl/mpwm_dp.sv =====
`default_nettype none
module mpwm_dp (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire mpwm_pkg::cmd_t cmd,
    output mpwm_pkg::sts_t      sts,
    input  wire logic [2:0]     opcode,
    input  wire logic [7:0]     data_byte,
    input  wire logic [7:0]     ticker_id,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output logic [7:0]          found_ticker,
    output logic                match_valid,
    output logic [2:0]          status,
    output logic                last
);
    import mpwm_pkg::*;

    // request and loader state
    logic [2:0]     op_reg, op_next;
    logic [BW-1:0]  byte_reg, byte_next;
    logic [7:0]     tick_reg, tick_next;
    logic           built_reg, built_next;
    logic           broken_reg, broken_next;
    logic [NW-1:0]  cursor_reg, cursor_next;
    logic [LW-1:0]  len_reg, len_next;
    logic [NCW-1:0] ncnt_reg, ncnt_next;
    logic [PCW-1:0] pcnt_reg, pcnt_next;
    // scan state
    logic [NW-1:0]  scan_reg, scan_next;
    logic [HW-1:0]  wh_reg, wh_next;
    logic [TPW-1:0] tp_reg, tp_next;
    // sequencing and walk registers
    logic [TTW-1:0] clr_reg, clr_next;
    logic [BW-1:0]  chr_reg, chr_next;
    logic [NCW-1:0] qhead_reg, qhead_next;
    logic [NCW-1:0] qtail_reg, qtail_next;
    logic [NW-1:0]  v_reg, v_next;
    logic [NW-1:0]  f_reg, f_next;
    logic [NW-1:0]  u_reg, u_next;
    logic [NW-1:0]  s_reg, s_next;
    logic [NW-1:0]  so_reg, so_next;
    logic [PCW-1:0] p_reg, p_next;
    logic [PCW-1:0] pn_reg, pn_next;
    logic [7:0]     th_reg, th_next;
    logic           cond_reg, cond_next;
    logic [HCW-1:0] hc_reg, hc_next;
    logic           ovf_reg, ovf_next;
    logic           pend_v_reg, pend_v_next;
    logic [7:0]     pend_t_reg, pend_t_next;
    logic [2:0]     stat_reg, stat_next;
    // result register
    logic           rv_reg, rv_next;
    logic [7:0]     rt_reg, rt_next;
    logic           rm_reg, rm_next;
    logic [2:0]     rs_reg, rs_next;
    logic           rl_reg, rl_next;

    // memory ports
    logic           tt_we;
    logic [TTW-1:0] tt_wa, tt_ra;
    logic [NW-1:0]  tt_wd, tt_q;
    logic           fl_we;
    logic [NW-1:0]  fl_wa, fl_ra, fl_wd, fl_q;
    logic           ol_we;
    logic [NW-1:0]  ol_wa, ol_ra, ol_wd, ol_q;
    logic           hd_we;
    logic [NW-1:0]  hd_wa, hd_ra;
    logic [PCW-1:0] hd_wd, hd_q;
    logic           pt_we;
    logic [PW-1:0]  pt_wa, pt_ra;
    logic [PCW-1:0] pn_q;
    logic [LW-1:0]  pl_q;
    logic [7:0]     pk_q;
    logic           bq_we;
    logic [NW-1:0]  bq_wa, bq_ra, bq_wd, bq_q;
    logic           sn_we, sn_re, sn_wd, sn_q;
    logic [TW-1:0]  sn_wa, sn_ra;

    logic           out_free, out_load;
    logic [7:0]     out_t;
    logic           out_m, out_l;
    logic [2:0]     out_s;
    logic           len_zero, node_full, close_bad, q_full, new_hit, hc_full;
    logic           hit_cond;
    logic [PCW-1:0] p_m1;

    mpwm_ram #(.W(NW), .D(TTD)) u_tt (
        .clk(clk), .we(tt_we), .waddr(tt_wa), .wdata(tt_wd),
        .re(1'b1), .raddr(tt_ra), .rdata(tt_q));
    mpwm_ram #(.W(NW), .D(NODES)) u_fail (
        .clk(clk), .we(fl_we), .waddr(fl_wa), .wdata(fl_wd),
        .re(1'b1), .raddr(fl_ra), .rdata(fl_q));
    mpwm_ram #(.W(NW), .D(NODES)) u_outl (
        .clk(clk), .we(ol_we), .waddr(ol_wa), .wdata(ol_wd),
        .re(1'b1), .raddr(ol_ra), .rdata(ol_q));
    mpwm_ram #(.W(PCW), .D(NODES)) u_head (
        .clk(clk), .we(hd_we), .waddr(hd_wa), .wdata(hd_wd),
        .re(1'b1), .raddr(hd_ra), .rdata(hd_q));
    mpwm_ram #(.W(PCW), .D(PATTERNS)) u_pnext (
        .clk(clk), .we(pt_we), .waddr(pt_wa), .wdata(hd_q),
        .re(1'b1), .raddr(pt_ra), .rdata(pn_q));
    mpwm_ram #(.W(LW), .D(PATTERNS)) u_plen (
        .clk(clk), .we(pt_we), .waddr(pt_wa), .wdata(len_reg),
        .re(1'b1), .raddr(pt_ra), .rdata(pl_q));
    mpwm_ram #(.W(8), .D(PATTERNS)) u_ptick (
        .clk(clk), .we(pt_we), .waddr(pt_wa), .wdata(tick_reg),
        .re(1'b1), .raddr(pt_ra), .rdata(pk_q));
    mpwm_ram #(.W(NW), .D(NODES)) u_queue (
        .clk(clk), .we(bq_we), .waddr(bq_wa), .wdata(bq_wd),
        .re(1'b1), .raddr(bq_ra), .rdata(bq_q));
    mpwm_ram #(.W(1), .D(TICKERS)) u_seen (
        .clk(clk), .we(sn_we), .waddr(sn_wa), .wdata(sn_wd),
        .re(sn_re), .raddr(sn_ra), .rdata(sn_q));

    assign out_free  = !rv_reg || !rsp_stall;
    assign len_zero  = (len_reg == '0);
    assign node_full = (ncnt_reg >= NCW'(NODES));
    assign close_bad = broken_reg || (!len_zero && pcnt_reg >= PCW'(PATTERNS));
    assign q_full    = (qtail_reg >= NCW'(NODES));
    assign hc_full   = (hc_reg >= HCW'(MAX_MATCHES));
    assign new_hit   = cond_reg && !sn_q;
    assign p_m1      = p_reg - 1'b1;
    assign hit_cond  = (pl_q >= LW'(1)) && (pl_q <= LW'(MAX_PATTERN_LEN)) &&
                       ((tp_reg == TPW'(pl_q)) || !wh_reg[pl_q]);

    always_comb
    begin
        sts.op        = op_reg;
        sts.built     = built_reg;
        sts.broken    = broken_reg;
        sts.len_full  = (len_reg >= LW'(MAX_PATTERN_LEN));
        sts.clr_last  = (clr_reg == TTW'(TTD - 1));
        sts.chr_last  = (chr_reg == BW'(ALPHABET - 1));
        sts.q_empty   = (qhead_reg >= qtail_reg);
        sts.s_zero    = (s_reg == '0);
        sts.p_zero    = (p_reg == '0);
        sts.check_go  = ((op_reg == OP_END_TEXT) || !is_word(byte_reg)) && (tp_reg != '0);
        sts.seen_wait = new_hit && !hc_full && pend_v_reg && !out_free;
        sts.out_free  = out_free;
    end

    always_comb
    begin
        op_next = op_reg;   byte_next = byte_reg;   tick_next = tick_reg;
        built_next = built_reg;   broken_next = broken_reg;
        cursor_next = cursor_reg; len_next = len_reg;
        ncnt_next = ncnt_reg;     pcnt_next = pcnt_reg;
        scan_next = scan_reg;     wh_next = wh_reg;   tp_next = tp_reg;
        clr_next = clr_reg;       chr_next = chr_reg;
        qhead_next = qhead_reg;   qtail_next = qtail_reg;
        v_next = v_reg;  f_next = f_reg;  u_next = u_reg;
        s_next = s_reg;  so_next = so_reg;
        p_next = p_reg;  pn_next = pn_reg;  th_next = th_reg;  cond_next = cond_reg;
        hc_next = hc_reg;  ovf_next = ovf_reg;
        pend_v_next = pend_v_reg;  pend_t_next = pend_t_reg;
        stat_next = stat_reg;

        tt_we = 1'b0;  tt_wa = '0;  tt_wd = '0;  tt_ra = '0;
        fl_we = 1'b0;  fl_wa = '0;  fl_wd = '0;  fl_ra = '0;
        ol_we = 1'b0;  ol_wa = '0;  ol_wd = '0;  ol_ra = '0;
        hd_we = 1'b0;  hd_wa = '0;  hd_wd = '0;  hd_ra = '0;
        pt_we = 1'b0;  pt_wa = '0;  pt_ra = '0;
        bq_we = 1'b0;  bq_wa = '0;  bq_wd = '0;  bq_ra = '0;
        sn_we = 1'b0;  sn_wa = '0;  sn_wd = 1'b0;  sn_re = 1'b0;  sn_ra = '0;

        out_load = 1'b0;  out_t = '0;  out_m = 1'b0;  out_s = STAT_OK;  out_l = 1'b1;

        if (cmd.accept)
        begin
            op_next     = opcode;
            byte_next   = data_byte;
            tick_next   = ticker_id;
            hc_next     = '0;
            ovf_next    = 1'b0;
            pend_v_next = 1'b0;
            chr_next    = '0;
        end

        case (cmd.step)
            CS_CLR:
            begin
                tt_we = 1'b1;
                tt_wa = clr_reg;
                if (clr_reg < TTW'(NODES))
                begin
                    hd_we = 1'b1;
                    hd_wa = clr_reg[NW-1:0];
                end
                if (clr_reg < TTW'(TICKERS))
                begin
                    sn_we = 1'b1;
                    sn_wa = clr_reg[TW-1:0];
                end
                clr_next = clr_reg + 1'b1;
            end
            CS_DECODE:
            begin
                stat_next = STAT_OK;
                case (op_reg)
                    OP_PAT_BYTE:
                    begin
                        if (built_reg)
                        begin
                            stat_next = STAT_PHASE;
                        end
                        else if (!broken_reg && sts.len_full)
                        begin
                            broken_next = 1'b1;
                            stat_next   = STAT_TOO_LONG;
                        end
                    end
                    OP_END_PAT:
                    begin
                        if (built_reg)
                        begin
                            stat_next = STAT_PHASE;
                        end
                    end
                    OP_BUILD:
                    begin
                        if (built_reg)
                        begin
                            stat_next = STAT_PHASE;
                        end
                        else
                        begin
                            cursor_next = '0;
                            len_next    = '0;
                            broken_next = 1'b0;
                        end
                    end
                    OP_TEXT, OP_END_TEXT:
                    begin
                        if (!built_reg)
                        begin
                            stat_next = STAT_PHASE;
                        end
                    end
                    OP_CLEAR:
                    begin
                        ncnt_next   = NCW'(1);
                        pcnt_next   = '0;
                        cursor_next = '0;
                        len_next    = '0;
                        broken_next = 1'b0;
                        built_next  = 1'b0;
                        scan_next   = '0;
                        tp_next     = '0;
                        wh_next     = '0;
                        clr_next    = '0;
                    end
                    default:
                    begin
                        stat_next = STAT_OK;
                    end
                endcase
            end
            CS_ACK:
            begin
                out_load = out_free;
                out_s    = stat_reg;
            end
            CS_P_RD:
            begin
                tt_ra = {cursor_reg, fold(byte_reg)};
            end
            CS_P_EV:
            begin
                if (tt_q == '0 && node_full)
                begin
                    broken_next = 1'b1;
                    stat_next   = STAT_NODE_FULL;
                end
                else if (tt_q == '0)
                begin
                    tt_we       = 1'b1;
                    tt_wa       = {cursor_reg, fold(byte_reg)};
                    tt_wd       = ncnt_reg[NW-1:0];
                    cursor_next = ncnt_reg[NW-1:0];
                    ncnt_next   = ncnt_reg + 1'b1;
                    len_next    = len_reg + 1'b1;
                end
                else
                begin
                    cursor_next = tt_q;
                    len_next    = len_reg + 1'b1;
                end
            end
            CS_E_RD:
            begin
                hd_ra = cursor_reg;
            end
            CS_E_WR:
            begin
                if (close_bad)
                begin
                    stat_next = STAT_TOO_LONG;
                end
                else if (!len_zero)
                begin
                    pt_we     = 1'b1;
                    pt_wa     = pcnt_reg[PW-1:0];
                    hd_we     = 1'b1;
                    hd_wa     = cursor_reg;
                    hd_wd     = pcnt_reg + 1'b1;
                    pcnt_next = pcnt_reg + 1'b1;
                end
                cursor_next = '0;
                len_next    = '0;
                broken_next = 1'b0;
            end
            CS_B_INIT:
            begin
                fl_we      = 1'b1;
                ol_we      = 1'b1;
                chr_next   = '0;
                qhead_next = '0;
                qtail_next = '0;
            end
            CS_B0_RD:
            begin
                tt_ra = {NW'(0), chr_reg};
            end
            CS_B0_EV:
            begin
                if (tt_q != '0 && !q_full)
                begin
                    fl_we      = 1'b1;
                    fl_wa      = tt_q;
                    bq_we      = 1'b1;
                    bq_wa      = qtail_reg[NW-1:0];
                    bq_wd      = tt_q;
                    qtail_next = qtail_reg + 1'b1;
                end
                chr_next = chr_reg + 1'b1;
            end
            CS_BQ:
            begin
                if (sts.q_empty)
                begin
                    built_next = 1'b1;
                end
                else
                begin
                    bq_ra      = qhead_reg[NW-1:0];
                    qhead_next = qhead_reg + 1'b1;
                end
            end
            CS_BQ_EV:
            begin
                v_next = bq_q;
                fl_ra  = bq_q;
            end
            CS_BF_EV:
            begin
                f_next = fl_q;
                hd_ra  = fl_q;
                ol_ra  = fl_q;
            end
            CS_BO:
            begin
                ol_we    = 1'b1;
                ol_wa    = v_reg;
                ol_wd    = (hd_q != '0) ? f_reg : ol_q;
                chr_next = '0;
            end
            CS_BC_RD1:
            begin
                tt_ra = {v_reg, chr_reg};
            end
            CS_BC_RD2:
            begin
                u_next = tt_q;
                tt_ra  = {f_reg, chr_reg};
            end
            CS_BC_EV:
            begin
                if (u_reg == '0)
                begin
                    tt_we = 1'b1;
                    tt_wa = {v_reg, chr_reg};
                    tt_wd = tt_q;
                end
                else if (!q_full)
                begin
                    fl_we      = 1'b1;
                    fl_wa      = u_reg;
                    fl_wd      = tt_q;
                    bq_we      = 1'b1;
                    bq_wa      = qtail_reg[NW-1:0];
                    bq_wd      = u_reg;
                    qtail_next = qtail_reg + 1'b1;
                end
                chr_next = chr_reg + 1'b1;
            end
            CS_S_START:
            begin
                s_next = scan_reg;
            end
            CS_S_NODE:
            begin
                hd_ra = s_reg;
                ol_ra = s_reg;
            end
            CS_S_NH:
            begin
                p_next  = hd_q;
                so_next = ol_q;
            end
            CS_S_P:
            begin
                if (sts.p_zero)
                begin
                    s_next = so_reg;
                end
                else
                begin
                    pt_ra = p_m1[PW-1:0];
                end
            end
            CS_S_PE:
            begin
                cond_next = hit_cond;
                pn_next   = pn_q;
                th_next   = pk_q;
                sn_re     = 1'b1;
                sn_ra     = tick_slot(pk_q);
            end
            CS_S_SEEN:
            begin
                if (!sts.seen_wait)
                begin
                    if (new_hit && !hc_full)
                    begin
                        if (pend_v_reg)
                        begin
                            out_load = 1'b1;
                            out_t    = pend_t_reg;
                            out_m    = 1'b1;
                            out_l    = 1'b0;
                        end
                        pend_v_next = 1'b1;
                        pend_t_next = th_reg;
                        sn_we       = 1'b1;
                        sn_wa       = tick_slot(th_reg);
                        sn_wd       = 1'b1;
                        hc_next     = hc_reg + 1'b1;
                    end
                    else if (new_hit)
                    begin
                        ovf_next = 1'b1;
                    end
                    p_next = pn_reg;
                end
            end
            CS_S_ADV:
            begin
                tt_ra = {scan_reg, fold(byte_reg)};
            end
            CS_S_ADV2:
            begin
                scan_next = tt_q;
                wh_next   = {wh_reg[HW-2:0], is_word(byte_reg)};
                if (tp_reg != TPW'(MAX_PATTERN_LEN + 1))
                begin
                    tp_next = tp_reg + 1'b1;
                end
            end
            CS_S_SCLR:
            begin
                sn_we     = 1'b1;
                sn_wa     = chr_reg[TW-1:0];
                chr_next  = chr_reg + 1'b1;
                wh_next   = '0;
                scan_next = '0;
                tp_next   = '0;
            end
            CS_S_FIN:
            begin
                out_load = out_free;
                out_t    = pend_v_reg ? pend_t_reg : 8'd0;
                out_m    = pend_v_reg;
                out_s    = ovf_reg ? STAT_OVERFLOW : STAT_OK;
            end
            default:
            begin
                stat_next = stat_reg;
            end
        endcase

        // hold the result register while the receiver stalls
        rv_next = rv_reg && rsp_stall;
        rt_next = rt_reg;  rm_next = rm_reg;  rs_next = rs_reg;  rl_next = rl_reg;
        if (out_load)
        begin
            rv_next = 1'b1;
            rt_next = out_t;
            rm_next = out_m;
            rs_next = out_s;
            rl_next = out_l;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            built_reg  <= 1'b0;
            broken_reg <= 1'b0;
            cursor_reg <= '0;
            len_reg    <= '0;
            ncnt_reg   <= NCW'(1);
            pcnt_reg   <= '0;
            scan_reg   <= '0;
            wh_reg     <= '0;
            tp_reg     <= '0;
            clr_reg    <= '0;
            rv_reg     <= 1'b0;
        end
        else
        begin
            built_reg  <= built_next;
            broken_reg <= broken_next;
            cursor_reg <= cursor_next;
            len_reg    <= len_next;
            ncnt_reg   <= ncnt_next;
            pcnt_reg   <= pcnt_next;
            scan_reg   <= scan_next;
            wh_reg     <= wh_next;
            tp_reg     <= tp_next;
            clr_reg    <= clr_next;
            rv_reg     <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        byte_reg   <= byte_next;
        tick_reg   <= tick_next;
        chr_reg    <= chr_next;
        qhead_reg  <= qhead_next;
        qtail_reg  <= qtail_next;
        v_reg      <= v_next;
        f_reg      <= f_next;
        u_reg      <= u_next;
        s_reg      <= s_next;
        so_reg     <= so_next;
        p_reg      <= p_next;
        pn_reg     <= pn_next;
        th_reg     <= th_next;
        cond_reg   <= cond_next;
        hc_reg     <= hc_next;
        ovf_reg    <= ovf_next;
        pend_v_reg <= pend_v_next;
        pend_t_reg <= pend_t_next;
        stat_reg   <= stat_next;
        rt_reg     <= rt_next;
        rm_reg     <= rm_next;
        rs_reg     <= rs_next;
        rl_reg     <= rl_next;
    end

    assign rsp_valid    = rv_reg;
    assign found_ticker = rt_reg;
    assign match_valid  = rm_reg;
    assign status       = rs_reg;
    assign last         = rl_reg;
endmodule
`default_nettype wire

// ===== hdl/multi_pattern_word_matcher.sv =====
// Case-folding multi-pattern matcher that reports whole-word hits by ticker id.
// Request channel: req_valid / req_stall with opcode, data_byte, ticker_id.
// Load patterns byte by byte, close each with a ticker id, issue one build,
// then stream text bytes and finish each text with an end-text request.
// Response channel: rsp_valid / rsp_stall with found_ticker, match_valid,
// status and last. Every request answers with one or more responses; the
// final one carries last. A confirmed hit is held back until the next hit
// is confirmed, and the last held hit rides on the final response.
// A request answered at once (wrong phase, spare opcode) passes through
// accept, decode and response; a text byte through accept, decode, start,
// transition table read, advance and response. A right-edge walk visits each
// node on the output chain and each pattern at each node; end text swaps the
// table read and advance for a sweep of the seen map. The build visits each
// byte value for the root, then each queued node and its byte values, all
// through the single read port of the transition table memory.
// Reset and clear: a clearing pass sweeps the transition table (and the
// pattern heads and seen map) before any request is taken.
// A stalled receiver holds the response register; the block runs on until its
// next response is due, then waits there, holding req_stall high.
`default_nettype none
module multi_pattern_word_matcher (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_stall,
    input  wire logic [2:0] opcode,
    input  wire logic [7:0] data_byte,
    input  wire logic [7:0] ticker_id,
    output logic            rsp_valid,
    input  wire logic       rsp_stall,
    output logic [7:0]      found_ticker,
    output logic            match_valid,
    output logic [2:0]      status,
    output logic            last
);
    import mpwm_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequence every request step by step
    mpwm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .sts       (sts),
        .cmd       (cmd),
        .req_stall (req_stall)
    );

    // hold the trie, links, pattern lists, scan state and response register
    mpwm_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .opcode       (opcode),
        .data_byte    (data_byte),
        .ticker_id    (ticker_id),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .found_ticker (found_ticker),
        .match_valid  (match_valid),
        .status       (status),
        .last         (last)
    );
endmodule
`default_nettype wire
